// ===== rtl/ecg_pkg.sv =====
package ecg_pkg;

  localparam int FracBits   = 16;
  localparam int CountWidth = 16;
  localparam int ProgWidth  = FracBits + 1;
  localparam int DataWidth  = 32;

  localparam logic [ProgWidth-1:0] OneQ  = ProgWidth'(1) << FracBits;
  localparam logic [ProgWidth-1:0] HalfQ = ProgWidth'(1) << (FracBits - 1);
  // round(1.70154 * 2^FracBits)
  localparam logic [ProgWidth:0] BackC =
    (ProgWidth+1)'(((64'd170154 << FracBits) + 64'd50000) / 64'd100000);

  localparam logic [15:0] DurationReset = 16'd60;
  localparam logic [3:0]  PowerReset    = 4'd1;
  localparam logic [2:0]  KindReset     = 3'd0;

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_POWER    = 2'd1,
    REG_KIND     = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_LINEAR   = 3'd0,
    KIND_EASE_IN  = 3'd1,
    KIND_EASE_OUT = 3'd2,
    KIND_IN_OUT   = 3'd3,
    KIND_BACK_IN  = 3'd4
  } curve_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROG,
    ST_PREP,
    ST_POW,
    ST_BACK1,
    ST_BACK2,
    ST_FACTOR,
    ST_SCALE,
    ST_OUT
  } ecg_state_t;

  typedef struct packed {
    logic load;        // apply restart and first half of the tick
    logic div_start;
    logic div_step;
    logic prog_update;
    logic pow_init;
    logic pow_step;
    logic back1;
    logic back2;
    logic factor;
    logic scale;
  } ecg_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic pow_done;
    logic back_kind;
  } ecg_status_t;

endpackage

// ===== rtl/ecg_in_if.sv =====
interface ecg_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic advance;
  logic signed [31:0] start_value;
  logic signed [31:0] end_value;
  modport source (output valid, restart, advance, start_value, end_value, input ready);
  modport sink (input valid, restart, advance, start_value, end_value, output ready);
endinterface

// ===== rtl/ecg_out_if.sv =====
interface ecg_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] eased_value;
  logic [16:0] progress;
  logic finished;
  modport source (output valid, eased_value, progress, finished, input ready);
  modport sink (input valid, eased_value, progress, finished, output ready);
endinterface

// ===== rtl/ecg_ctrl.sv =====
module ecg_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_load,
  input  logic                    out_busy,
  input  logic                    advance,
  input  ecg_pkg::ecg_status_t    status,
  output ecg_pkg::ecg_cmd_t       cmd
);

  ecg_pkg::ecg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ecg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = advance ? ecg_pkg::ST_DIV : ecg_pkg::ST_PREP;
        end
      end
      ecg_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next = ecg_pkg::ST_PROG;
      end
      ecg_pkg::ST_PROG: begin
        if (!status.div_needed || status.div_done) begin
          cmd.prog_update = 1'b1;
          state_next = ecg_pkg::ST_PREP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ecg_pkg::ST_PREP: begin
        cmd.pow_init = 1'b1;
        state_next = ecg_pkg::ST_POW;
      end
      ecg_pkg::ST_POW: begin
        if (status.pow_done) begin
          state_next = status.back_kind ? ecg_pkg::ST_BACK1 : ecg_pkg::ST_FACTOR;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      ecg_pkg::ST_BACK1: begin
        cmd.back1 = 1'b1;
        state_next = ecg_pkg::ST_BACK2;
      end
      ecg_pkg::ST_BACK2: begin
        cmd.back2 = 1'b1;
        state_next = ecg_pkg::ST_FACTOR;
      end
      ecg_pkg::ST_FACTOR: begin
        cmd.factor = 1'b1;
        state_next = ecg_pkg::ST_SCALE;
      end
      ecg_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ecg_pkg::ST_OUT;
      end
      ecg_pkg::ST_OUT: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_next = ecg_pkg::ST_IDLE;
        end
      end
      default: state_next = ecg_pkg::ST_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ecg_pkg::ST_IDLE) else $error("load outside idle");
  a_out_after_scale: assert property (@(posedge clk) disable iff (rst)
    state == ecg_pkg::ST_SCALE |=> state == ecg_pkg::ST_OUT) else $error("scale not followed by out");
  a_single_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.pow_step)) else $error("two units stepped");

endmodule

// ===== rtl/ecg_datapath.sv =====
module ecg_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ecg_pkg::ecg_cmd_t     cmd,
  output ecg_pkg::ecg_status_t  status,
  input  logic                  restart,
  input  logic                  advance,
  input  logic signed [31:0]    start_value,
  input  logic signed [31:0]    end_value,
  input  logic [15:0]           duration_ticks,
  input  logic [3:0]            curve_power,
  input  logic [2:0]            curve_kind,
  output logic signed [31:0]    eased_value,
  output logic [16:0]           progress,
  output logic                  finished
);

  localparam int PW = ecg_pkg::ProgWidth;
  localparam int CW = ecg_pkg::CountWidth;
  localparam int FB = ecg_pkg::FracBits;
  localparam int NumW = CW + FB;
  localparam int StepW = $clog2(NumW + 1);

  // persistent state
  logic [CW-1:0] tick_count;
  logic [PW-1:0] prog;
  logic          end_flag;

  // per-item registers
  logic signed [31:0] start_r;
  logic signed [32:0] span;
  logic [NumW-1:0]    quo;
  logic [CW:0]        rem;
  logic [StepW-1:0]   div_cnt;
  logic               div_busy;
  logic [PW-1:0]      pw_base;
  logic [PW-1:0]      pw_acc;
  logic [3:0]         pw_cnt;
  logic               use_out;
  logic signed [PW+1:0] inner;
  logic signed [PW+2:0] factor;
  logic signed [66:0] scaled;

  // tick rule, first half: wrap, increment, flag and cap
  logic [CW-1:0] cnt_a, cnt_b, cnt_c;
  logic [PW-1:0] prog_a;
  logic          flag_a, flag_b;
  always_comb begin
    cnt_a  = restart ? '0 : tick_count;
    prog_a = restart ? '0 : prog;
    flag_a = restart ? 1'b0 : end_flag;
    if (flag_a && (cnt_a >= duration_ticks)) begin
      cnt_a = '0;
      prog_a = '0;
      flag_a = 1'b0;
    end
    cnt_b = (cnt_a != '1) ? cnt_a + 1'b1 : cnt_a;
    flag_b = flag_a | (prog_a >= ecg_pkg::OneQ);
    cnt_c = (cnt_b > duration_ticks) ? duration_ticks : cnt_b;
  end

  // restoring divider, one quotient bit per cycle
  logic [CW+1:0] rem_sh;
  logic [CW+1:0] rem_diff;
  always_comb begin
    rem_sh = {rem, quo[NumW-1]};
    rem_diff = rem_sh - {2'b00, duration_ticks};
  end

  logic [2*PW-1:0] pw_prod;
  assign pw_prod = pw_acc * pw_base;

  logic [PW:0] one_minus;
  always_comb one_minus = {1'b0, ecg_pkg::OneQ} - {1'b0, prog};

  logic [2*PW+1:0] back_mul;
  assign back_mul = (ecg_pkg::BackC + {1'b0, ecg_pkg::OneQ}) * {{(PW+1){1'b0}}, prog};
  logic signed [2*PW+3:0] pb_prod;
  assign pb_prod = $signed({1'b0, pw_acc}) * inner;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      prog <= '0;
      end_flag <= 1'b0;
      div_busy <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (advance) begin
          tick_count <= cnt_c;
          end_flag <= flag_b;
          prog <= prog_a;
        end else if (restart) begin
          tick_count <= '0;
          prog <= '0;
          end_flag <= 1'b0;
        end
      end
      if (cmd.div_start) begin
        div_busy <= (duration_ticks != '0);
      end else if (cmd.div_step && div_cnt == StepW'(NumW - 1)) begin
        div_busy <= 1'b0;
      end
      if (cmd.prog_update) begin
        if (duration_ticks == '0) begin
          prog <= ecg_pkg::OneQ;
        end else if (quo > NumW'(ecg_pkg::OneQ)) begin
          prog <= ecg_pkg::OneQ;
        end else begin
          prog <= quo[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= start_value;
      span <= 33'(end_value) - 33'(start_value);
    end
    if (cmd.div_start) begin
      quo <= {tick_count, {FB{1'b0}}};
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!rem_diff[CW+1]) begin
        rem <= rem_diff[CW:0];
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CW:0];
        quo <= {quo[NumW-2:0], 1'b0};
      end
    end
    if (cmd.pow_init) begin
      use_out <= (curve_kind == ecg_pkg::KIND_EASE_OUT) ||
                 ((curve_kind == ecg_pkg::KIND_IN_OUT) && (prog >= ecg_pkg::HalfQ));
      pw_base <= ((curve_kind == ecg_pkg::KIND_EASE_OUT) ||
                  ((curve_kind == ecg_pkg::KIND_IN_OUT) && (prog >= ecg_pkg::HalfQ)))
                 ? one_minus[PW-1:0] : prog;
      pw_acc <= ecg_pkg::OneQ;
      pw_cnt <= curve_power;
    end else if (cmd.pow_step) begin
      pw_acc <= pw_prod[FB +: PW];
      pw_cnt <= pw_cnt - 1'b1;
    end
    if (cmd.back1) begin
      inner <= $signed({1'b0, back_mul[FB +: PW+1]}) - $signed({1'b0, ecg_pkg::BackC});
    end
    if (cmd.back2) begin
      factor <= (PW+3)'(pb_prod >>> FB);
    end else if (cmd.factor) begin
      case (curve_kind)
        ecg_pkg::KIND_EASE_IN, ecg_pkg::KIND_EASE_OUT, ecg_pkg::KIND_IN_OUT:
          factor <= use_out
            ? $signed({2'b00, ecg_pkg::OneQ}) - $signed({2'b00, pw_acc})
            : $signed({2'b00, pw_acc});
        ecg_pkg::KIND_BACK_IN: factor <= factor;
        default: factor <= $signed({2'b00, prog});
      endcase
    end
    if (cmd.scale) begin
      scaled <= 67'(span * factor);
    end
  end

  logic signed [67:0] sum;
  always_comb begin
    sum = 68'(start_r) + 68'(scaled >>> FB);
    if (sum > 68'sh7FFFFFFF) begin
      eased_value = 32'sh7FFFFFFF;
    end else if (sum < -68'sh80000000) begin
      eased_value = -32'sh80000000;
    end else begin
      eased_value = sum[31:0];
    end
  end

  assign progress = prog;
  assign finished = end_flag;
  assign status.div_needed = div_busy;
  assign status.div_done = !div_busy;
  assign status.pow_done = (pw_cnt == '0);
  assign status.back_kind = (curve_kind == ecg_pkg::KIND_BACK_IN);

  a_prog_cap: assert property (@(posedge clk) disable iff (rst)
    prog <= ecg_pkg::OneQ) else $error("progress above one");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load) && $past(advance) |-> tick_count <= $past(duration_ticks) ||
    $past(duration_ticks) == '0) else $error("count above duration");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_cnt == '0) else $error("divider not cleared");

endmodule

// ===== rtl/easing_curve_generator_unit.sv =====
// Power easing generator: each request may restart and/or advance a tick timer, then
// evaluates linear, ease-in, ease-out, in-out or back-in curves between start_value and
// end_value (Q16.16, saturated). One request at a time, stepped through accept, prep,
// final power check, factor, scale and output load. With advance set, the bit-serial
// progress divider runs before prep (no steps when duration_ticks is zero); there is
// one power step per unit of curve_power (up to 15), and back-in adds BACK1 and BACK2.
// The result sits in an output register so the next request is taken while it waits.
module easing_curve_generator_unit (
  input  logic        clk,
  input  logic        rst,
  ecg_in_if.sink      in_ch,
  ecg_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0] duration_ticks;
  logic [3:0]  curve_power;
  logic [2:0]  curve_kind;
  logic        wr_en;
  ecg_pkg::reg_index_t wr_idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign wr_idx = ecg_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ticks <= ecg_pkg::DurationReset;
      curve_power <= ecg_pkg::PowerReset;
      curve_kind <= ecg_pkg::KindReset;
    end else if (wr_en) begin
      case (wr_idx)
        ecg_pkg::REG_DURATION: duration_ticks <= pwdata[15:0];
        ecg_pkg::REG_POWER:    curve_power <= pwdata[3:0];
        ecg_pkg::REG_KIND:     curve_kind <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      ecg_pkg::REG_DURATION: prdata = {16'd0, duration_ticks};
      ecg_pkg::REG_POWER:    prdata = {28'd0, curve_power};
      ecg_pkg::REG_KIND:     prdata = {29'd0, curve_kind};
      default:               prdata = '0;
    endcase
  end

  ecg_pkg::ecg_cmd_t    cmd;
  ecg_pkg::ecg_status_t status;
  logic out_load;
  logic signed [31:0] dp_value;
  logic [16:0] dp_prog;
  logic dp_fin;

  // output register frees the datapath as soon as the result is captured
  logic out_valid;
  assign out_ch.valid = out_valid;

  ecg_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_load(out_load), .out_busy(out_valid && !out_ch.ready),
    .advance(in_ch.advance), .status(status), .cmd(cmd)
  );

  ecg_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .restart(in_ch.restart), .advance(in_ch.advance),
    .start_value(in_ch.start_value), .end_value(in_ch.end_value),
    .duration_ticks(duration_ticks), .curve_power(curve_power), .curve_kind(curve_kind),
    .eased_value(dp_value), .progress(dp_prog), .finished(dp_fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.eased_value <= dp_value;
      out_ch.progress <= dp_prog;
      out_ch.finished <= dp_fin;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && !out_ch.ready)) else $error("result overwritten");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> in_ch.ready) else $error("not idle after result");

endmodule

// ===== test/ecg_tb_scoreboard.sv =====
`timescale 1ns / 1ps
class easing_scoreboard;
  localparam longint OneQ   = 64'd65536;
  localparam longint HalfQ  = 64'd32768;
  localparam longint BackC  = ((64'd170154 << 16) + 64'd50000) / 64'd100000;
  localparam longint CountMax = 64'd65535;

  // mirrored timer state and configuration
  longint tick_cnt, prog_frac, end_flg;
  longint dur, pwr, kind;
  // expected results, one entry per request
  logic signed [31:0] eased_q[$];
  logic [16:0] prog_q[$];
  logic fin_q[$];
  int mismatches;

  function void reset_state();
    tick_cnt = 0; prog_frac = 0; end_flg = 0;
    dur = 60; pwr = 1; kind = 0;
    mismatches = 0;
  endfunction

  function longint floor_q(longint x);
    return x >>> 16;
  endfunction

  function longint pow_q(longint base, longint p);
    longint r;
    r = OneQ;
    for (int i = 0; i < p; i++) r = (r * base) >> 16;
    return r;
  endfunction

  function void tick();
    longint q;
    if (end_flg != 0 && tick_cnt >= dur) begin
      tick_cnt = 0; prog_frac = 0; end_flg = 0;
    end
    if (tick_cnt < CountMax) tick_cnt++;
    if (prog_frac >= OneQ) end_flg = 1;
    if (tick_cnt > dur) tick_cnt = dur;
    if (dur == 0) prog_frac = OneQ;
    else begin
      q = (tick_cnt << 16) / dur;
      prog_frac = q > OneQ ? OneQ : q;
    end
  endfunction

  function void note_request(bit rs, bit adv, logic signed [31:0] sv,
                             logic signed [31:0] ev);
    longint s, e, t, factor, inner, val;
    if (rs) begin
      tick_cnt = 0; prog_frac = 0; end_flg = 0;
    end
    if (adv) tick();
    s = sv; e = ev; t = prog_frac;
    case (kind)
      1: factor = pow_q(t, pwr);
      2: factor = OneQ - pow_q(OneQ - t, pwr);
      3: factor = (t < HalfQ) ? pow_q(t, pwr) : OneQ - pow_q(OneQ - t, pwr);
      4: begin
        inner = (((BackC + OneQ) * t) >> 16) - BackC;
        factor = floor_q(pow_q(t, pwr) * inner);
      end
      default: factor = t;
    endcase
    val = s + floor_q((e - s) * factor);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    eased_q.push_back(val[31:0]);
    prog_q.push_back(prog_frac[16:0]);
    fin_q.push_back(end_flg[0]);
  endfunction

  function void check_result(logic signed [31:0] ev, logic [16:0] pr, logic fin);
    logic signed [31:0] xe;
    logic [16:0] xp;
    logic xf;
    if (eased_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result eased=%0d", ev);
      return;
    end
    xe = eased_q.pop_front(); xp = prog_q.pop_front(); xf = fin_q.pop_front();
    if (ev !== xe || pr !== xp || fin !== xf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: eased %0d/%0d progress %0d/%0d finished %0b/%0b (exp/act)",
                 xe, ev, xp, pr, xf, fin);
    end
  endfunction

  function int pending();
    return eased_q.size();
  endfunction
endclass

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int WatchdogLimit = 20000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ecg_in_if  req_ch();
  ecg_out_if res_ch();

  easing_curve_generator_unit uut (
    .clk(clk), .rst(rst), .in_ch(req_ch.sink), .out_ch(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  easing_scoreboard sb;
  int idle_cycles;
  bit sink_calm;   // long stretch with no stalls on the result side
  bit done;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.eased_value, res_ch.progress, res_ch.finished);
      res_ch.ready <= sink_calm || ($urandom_range(99) >= 6);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // apb write: setup then access, register index by name
  task automatic write_reg(ecg_pkg::reg_index_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ecg_pkg::REG_DURATION: sb.dur = value[15:0];
      ecg_pkg::REG_POWER:    sb.pwr = value[3:0];
      default:               sb.kind = value[2:0];
    endcase
  endtask

  // one request, with optional random idle before it
  task automatic send_request(bit rs, bit adv, logic [31:0] sv, logic [31:0] ev,
                              bit calm);
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1; req_ch.restart <= rs; req_ch.advance <= adv;
    req_ch.start_value <= sv; req_ch.end_value <= ev;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(rs, adv, sv, ev);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sd65536 * $signed(32'($urandom_range(200))) - 32'sd6553600;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(65535)) << $urandom_range(15);
    endcase
  endfunction

  initial begin
    logic [15:0] durs[6];
    logic [31:0] extremes[4];
    sb = new();
    sb.reset_state();
    done = 0; sink_calm = 0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req_ch.valid = 0; req_ch.restart = 0; req_ch.advance = 0;
    req_ch.start_value = '0; req_ch.end_value = '0;
    res_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme positions under every curve, zero duration and power
    extremes = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff};
    for (int k = 0; k <= 4; k++) begin
      write_reg(ecg_pkg::REG_KIND, k);
      write_reg(ecg_pkg::REG_POWER, (k == 2) ? 0 : 8);
      write_reg(ecg_pkg::REG_DURATION, (k == 0) ? 0 : 2);
      send_request(1, 0, extremes[0], extremes[1], 1);
      send_request(0, 1, extremes[1], extremes[0], 1);
      send_request(0, 1, extremes[2], extremes[3], 1);
      send_request(0, 1, extremes[0], extremes[1], 1);
      send_request(0, 1, extremes[3], extremes[2], 1);
      // sender holds off until every result is back
      drain();
    end
    write_reg(ecg_pkg::REG_KIND, 7);
    write_reg(ecg_pkg::REG_DURATION, 32'h0000ffff);
    send_request(1, 1, 32'h12345678, 32'hedcba987, 1);
    drain();

    // random phases, mostly advancing through whole curves
    durs = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd20, 16'd65535};
    for (int ph = 0; ph < 24; ph++) begin
      write_reg(ecg_pkg::REG_DURATION, 32'(durs[$urandom_range(5)]));
      write_reg(ecg_pkg::REG_POWER, $urandom_range(15));
      write_reg(ecg_pkg::REG_KIND, $urandom_range(7));
      sink_calm = (ph == 10);
      for (int n = 0; n < 46; n++)
        send_request($urandom_range(99) < 5, $urandom_range(99) < 85,
                     rand_pos(), rand_pos(), ph == 10);
      drain();
    end
    sink_calm = 0;
    write_reg(ecg_pkg::REG_DURATION, 32'd60);
    write_reg(ecg_pkg::REG_POWER, 32'd1);
    write_reg(ecg_pkg::REG_KIND, 32'(ecg_pkg::KIND_LINEAR));

    done = 1;
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== easing_curve_generator_unit.f =====
rtl/ecg_pkg.sv
rtl/ecg_in_if.sv
rtl/ecg_out_if.sv
rtl/ecg_ctrl.sv
rtl/ecg_datapath.sv
rtl/easing_curve_generator_unit.sv
test/ecg_tb_scoreboard.sv
test/tb_top.sv
